// ===== sv/rdc_pkg.sv =====
`default_nettype none

package rdc_pkg;

   // field widths fixed by the item format
   localparam int RADIX_W             = 4;
   localparam int DIGIT_W             = 4;
   localparam int VALUE_WIDTH_DEFAULT = 31;

   // base limits and reset value
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 4'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 4'd9;
   localparam logic [RADIX_W-1:0] RADIX_RESET = 4'd2;

   // divider command from the controller
   typedef struct packed {
      logic load;
      logic start;
   } div_cmd_type;

   // divider status back to the controller
   typedef struct packed {
      logic busy;
      logic done;
      logic ge_radix;
   } div_stat_type;

   // clamp the register value into the supported base range
   function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] raw);
      logic [RADIX_W-1:0] r;
      r = raw;
      if (raw < RADIX_MIN) begin
         r = RADIX_MIN;
      end else if (raw > RADIX_MAX) begin
         r = RADIX_MAX;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/rdc_if.sv =====
`default_nettype none

// input channel: one value per item
interface rdc_req_if #(
   parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEFAULT
);
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

// result channel: one digit per item
interface rdc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [rdc_pkg::DIGIT_W-1:0]  digit;
   logic                         last;

   modport source (output valid, output digit, output last, input ready);
   modport sink   (input valid, input digit, input last, output ready);
endinterface

`default_nettype wire

// ===== sv/rdc_divider.sv =====
`default_nettype none

// bit-serial restoring divider by a small base, one quotient bit per cycle
module rdc_divider #(
   parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire  rdc_pkg::div_cmd_type       cmd,
   input  wire  [VALUE_WIDTH-1:0]           load_value,
   input  wire  [rdc_pkg::RADIX_W-1:0]      radix,
   output rdc_pkg::div_stat_type            stat,
   output logic [VALUE_WIDTH-1:0]           quot,
   output logic [rdc_pkg::RADIX_W-1:0]      rem
);

   localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

   logic [VALUE_WIDTH-1:0]      q_ff, q_in;
   logic [rdc_pkg::RADIX_W-1:0] r_ff, r_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        done_ff, done_in;
   logic [rdc_pkg::RADIX_W:0]   trial;
   logic                        fits;

   // partial remainder with the next dividend bit shifted in
   assign trial = {r_ff, q_ff[VALUE_WIDTH-1]};
   assign fits  = trial >= {1'b0, radix};

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      priority if (cmd.load) begin
         q_in = load_value;
      end else if (cmd.start) begin
         r_in   = '0;
         cnt_in = CNT_W'(VALUE_WIDTH);
      end else if (cnt_ff != '0) begin
         // one restoring step
         q_in    = {q_ff[VALUE_WIDTH-2:0], fits};
         r_in    = fits ? rdc_pkg::RADIX_W'(trial - {1'b0, radix})
                        : rdc_pkg::RADIX_W'(trial);
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   // data path
   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
   end

   assign stat.busy     = (cnt_ff != '0);
   assign stat.done     = done_ff;
   assign stat.ge_radix = (q_ff >= VALUE_WIDTH'(radix));
   assign quot          = q_ff;
   assign rem           = r_ff;

   // a step never runs while a new value loads
   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (cnt_ff == '0))
      else $error("divider loaded while busy");

   // remainder stays below the base while dividing
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) && !cmd.start && !cmd.load |=> (r_ff < radix))
      else $error("remainder out of range");

   // done follows the last step
   a_done_end: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (cnt_ff == '0))
      else $error("done while still dividing");

endmodule

`default_nettype wire

// ===== sv/rdc_digit_stack.sv =====
`default_nettype none

// remainder store, one write and one registered read per cycle
module rdc_digit_stack #(
   parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire                               clock,
   input  wire                               wr_en,
   input  wire  [$clog2(VALUE_WIDTH)-1:0]    wr_addr,
   input  wire  [rdc_pkg::DIGIT_W-1:0]       wr_data,
   input  wire                               rd_en,
   input  wire  [$clog2(VALUE_WIDTH)-1:0]    rd_addr,
   output logic [rdc_pkg::DIGIT_W-1:0]       rd_data
);

   logic [rdc_pkg::DIGIT_W-1:0] mem [VALUE_WIDTH];
   logic [rdc_pkg::DIGIT_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/radix_digit_converter.sv =====
// radix_digit_converter
// Converts an unsigned binary value into its digits in base 2..9.
// req_ch carries one value per item; rsp_ch returns one item per digit,
// most significant first, with last set on the least significant digit.
// csr_wr_en/csr_wr_data set the base; 0 and 1 act as 2, 10..15 as 9.
// Write the base only while no conversion is in flight.
// A value below the base gives one digit. Otherwise each division by the
// base is done bit-serially and each remainder is pushed to the digit
// store; the final quotient then goes out, followed by the stored
// remainders, each read from the store before it is sent.
// req_ch.ready is high only between conversions; the last digit can still
// wait in the output register while the next value is accepted.
// A stalled receiver holds the output register and the conversion waits.
// Reset (synchronous, active high) returns to idle, drops rsp_ch.valid
// and sets the base to 2.
`default_nettype none

module radix_digit_converter #(
   parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire                           clock,
   input  wire                           reset,
   rdc_req_if.sink                       req_ch,
   rdc_rsp_if.source                     rsp_ch,
   input  wire                           csr_wr_en,
   input  wire  [rdc_pkg::RADIX_W-1:0]   csr_wr_data
);

   localparam int ADDR_W = $clog2(VALUE_WIDTH);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_TEST = 6'b000010,
      S_DIV  = 6'b000100,
      S_HEAD = 6'b001000,
      S_RD   = 6'b010000,
      S_OUT  = 6'b100000
   } state_type;

   state_type                   state_ff, state_in;
   logic [ADDR_W-1:0]           cnt_ff, cnt_in;
   logic [rdc_pkg::RADIX_W-1:0] radix_ff, radix_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [rdc_pkg::DIGIT_W-1:0] rsp_digit_ff, rsp_digit_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic [rdc_pkg::RADIX_W-1:0] radix_eff;
   logic                        accept;
   logic                        slot_free;
   rdc_pkg::div_cmd_type        div_cmd;
   rdc_pkg::div_stat_type       div_stat;
   logic [VALUE_WIDTH-1:0]      quot;
   logic [rdc_pkg::RADIX_W-1:0] rem;
   logic                        push;
   logic                        rd_en;
   logic [ADDR_W-1:0]           rd_addr;
   logic [rdc_pkg::DIGIT_W-1:0] rd_data;

   assign radix_eff = rdc_pkg::eff_radix(radix_ff);
   assign accept    = req_ch.valid && req_ch.ready;
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.digit = rsp_digit_ff;
   assign rsp_ch.last  = rsp_last_ff;

   // base register
   assign radix_in = csr_wr_en ? csr_wr_data : radix_ff;

   // serial divider
   rdc_divider #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_divider (
      .clock      (clock),
      .reset      (reset),
      .cmd        (div_cmd),
      .load_value (req_ch.value),
      .radix      (radix_eff),
      .stat       (div_stat),
      .quot       (quot),
      .rem        (rem)
   );

   // remainder store
   rdc_digit_stack #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (cnt_ff),
      .wr_data (rem),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_addr = cnt_ff - 1'b1;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      div_cmd.load  = 1'b0;
      div_cmd.start = 1'b0;
      push          = 1'b0;
      rd_en         = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_digit_in  = rsp_digit_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               div_cmd.load = 1'b1;
               cnt_in       = '0;
               state_in     = S_TEST;
            end
         end
         S_TEST: begin
            if (div_stat.ge_radix) begin
               div_cmd.start = 1'b1;
               state_in      = S_DIV;
            end else begin
               state_in = S_HEAD;
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               push     = 1'b1;
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_TEST;
            end
         end
         S_HEAD: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_digit_in = quot[rdc_pkg::DIGIT_W-1:0];
               rsp_last_in  = (cnt_ff == '0);
               state_in     = (cnt_ff == '0) ? S_IDLE : S_RD;
            end
         end
         S_RD: begin
            rd_en    = 1'b1;
            cnt_in   = cnt_ff - 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_digit_in = rd_data;
               rsp_last_in  = (cnt_ff == '0);
               state_in     = (cnt_ff == '0) ? S_IDLE : S_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         radix_ff     <= rdc_pkg::RADIX_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         radix_ff     <= radix_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      rsp_digit_ff <= rsp_digit_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // every digit sent is below the base
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_digit_ff < radix_eff))
      else $error("digit not below base");

   // stored remainder count fits the store
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= ADDR_W'(VALUE_WIDTH - 1))
      else $error("digit count overflow");

   // the divider runs only during the divide phase
   a_div_phase: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> (state_ff == S_DIV))
      else $error("divider active outside divide phase");

   // a push always comes right after the divider finishes
   a_push_done: assert property (@(posedge clock) disable iff (reset)
      push |-> $past(div_stat.busy))
      else $error("remainder pushed without a division");

endmodule

`default_nettype wire

// ===== tb/rdc_digit_check.sv =====
`default_nettype none

module rdc_digit_check #(
   parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   input  wire                          req_ready,
   input  wire  [VALUE_WIDTH-1:0]       req_value,
   input  wire                          rsp_valid,
   input  wire                          rsp_ready,
   input  wire  [rdc_pkg::DIGIT_W-1:0]  rsp_digit,
   input  wire                          rsp_last,
   input  wire                          csr_wr_en,
   input  wire  [rdc_pkg::RADIX_W-1:0]  csr_wr_data,
   output int                           fail_count,
   output int                           digits_pending
);

   typedef struct packed {
      logic [rdc_pkg::DIGIT_W-1:0] digit;
      logic                        last;
   } digit_item_type;

   // base register as last written, raw 4-bit value
   logic [rdc_pkg::RADIX_W-1:0] base_raw;
   digit_item_type              digit_queue[$];
   digit_item_type              want;

   initial begin
      fail_count     = 0;
      digits_pending = 0;
      base_raw       = rdc_pkg::RADIX_RESET;
   end

   // divide repeatedly, then queue quotient and remainders msd first
   function automatic void queue_digits(input logic [VALUE_WIDTH-1:0]      value,
                                        input logic [rdc_pkg::RADIX_W-1:0] raw);
      logic [VALUE_WIDTH-1:0]      base;
      logic [VALUE_WIDTH-1:0]      quot;
      logic [rdc_pkg::DIGIT_W-1:0] rem_stack[64];
      int                          depth;
      digit_item_type              item;
      // out-of-range register values fold onto the nearest legal base
      if (raw < rdc_pkg::RADIX_MIN) begin
         base = VALUE_WIDTH'(rdc_pkg::RADIX_MIN);
      end else if (raw > rdc_pkg::RADIX_MAX) begin
         base = VALUE_WIDTH'(rdc_pkg::RADIX_MAX);
      end else begin
         base = VALUE_WIDTH'(raw);
      end
      quot  = value;
      depth = 0;
      while (quot >= base) begin
         rem_stack[depth] = rdc_pkg::DIGIT_W'(quot % base);
         quot             = quot / base;
         depth++;
      end
      item.digit = rdc_pkg::DIGIT_W'(quot);
      item.last  = (depth == 0);
      digit_queue.push_back(item);
      for (int i = depth - 1; i >= 0; i--) begin
         item.digit = rem_stack[i];
         item.last  = (i == 0);
         digit_queue.push_back(item);
      end
   endfunction

   // compare before queueing so a digit cannot match its own value's item
   always @(posedge clock) begin
      if (reset) begin
         base_raw = rdc_pkg::RADIX_RESET;
         digit_queue.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (digit_queue.size() == 0) begin
               fail_count++;
               $display("%0t unexpected digit %0d last %0b, none expected",
                        $time, rsp_digit, rsp_last);
            end else begin
               want = digit_queue.pop_front();
               if (rsp_digit !== want.digit || rsp_last !== want.last) begin
                  fail_count++;
                  $display({"%0t digit mismatch: expected digit %0d last %0b,",
                            " got digit %0d last %0b"},
                           $time, want.digit, want.last, rsp_digit, rsp_last);
               end
            end
         end
         if (req_valid && req_ready) begin
            queue_digits(req_value, base_raw);
         end
         if (csr_wr_en) begin
            base_raw = csr_wr_data;
         end
      end
      digits_pending = digit_queue.size();
   end

endmodule

`default_nettype wire

// ===== tb/radix_digit_converter_tb.sv =====
`default_nettype none

module radix_digit_converter_tb;

   localparam int VALUE_W = rdc_pkg::VALUE_WIDTH_DEFAULT;
   localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

   logic                        clock       = 1'b0;
   logic                        reset       = 1'b1;
   logic                        csr_wr_en   = 1'b0;
   logic [rdc_pkg::RADIX_W-1:0] csr_wr_data = rdc_pkg::RADIX_RESET;

   // receiver stall pattern, rotated each cycle and replaced now and then
   logic [15:0] stall_pattern = 16'hFFFF;
   int          pattern_age   = 0;

   int          fail_count;
   int          digits_pending;
   int          burst_left = 1;
   bit          gaps_on    = 1'b1;
   logic [rdc_pkg::RADIX_W-1:0] base_now = rdc_pkg::RADIX_RESET;

   rdc_req_if #(.VALUE_WIDTH(VALUE_W)) req_ch ();
   rdc_rsp_if rsp_ch ();

   always #2 clock = ~clock;

   radix_digit_converter #(
      .VALUE_WIDTH(VALUE_W)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   rdc_digit_check #(
      .VALUE_WIDTH(VALUE_W)
   ) digit_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .req_ready      (req_ch.ready),
      .req_value      (req_ch.value),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_digit      (rsp_ch.digit),
      .rsp_last       (rsp_ch.last),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .fail_count     (fail_count),
      .digits_pending (digits_pending)
   );

   // receiver side
   always @(negedge clock) begin
      rsp_ch.ready <= stall_pattern[0];
      if (pattern_age == 200) begin
         pattern_age   <= 0;
         stall_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF
                                                       : (16'($urandom) | 16'h0001);
      end else begin
         pattern_age   <= pattern_age + 1;
         stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
      end
   end

   // present one value, hold until accepted, then maybe open a gap
   task automatic send_value(input logic [VALUE_W-1:0] v);
      req_ch.valid <= 1'b1;
      req_ch.value <= v;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 8);
         if (gaps_on) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
   endtask

   // change the base once every digit is back and the block is quiet
   task automatic write_base(input logic [rdc_pkg::RADIX_W-1:0] raw);
      req_ch.valid <= 1'b0;
      while (digits_pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= raw;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      if (raw < rdc_pkg::RADIX_MIN) begin
         base_now = rdc_pkg::RADIX_MIN;
      end else if (raw > rdc_pkg::RADIX_MAX) begin
         base_now = rdc_pkg::RADIX_MAX;
      end else begin
         base_now = raw;
      end
   endtask

   // stimulus
   initial begin
      logic [VALUE_W-1:0]          v;
      logic [rdc_pkg::RADIX_W-1:0] raw;
      longint                      p;
      logic [rdc_pkg::RADIX_W-1:0] phase_bases[4];
      phase_bases  = '{4'd9, rdc_pkg::RADIX_MIN, 4'd0, 4'd15};
      req_ch.valid = 1'b0;
      req_ch.value = '0;
      rsp_ch.ready = 1'b0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // base 2 from reset: zero, one digit, longest digit strings
      send_value('0);
      send_value(1);
      send_value(2);
      send_value(3);
      send_value(VALUE_MAX);
      send_value({1'b1, {(VALUE_W-1){1'b0}}});
      send_value({(VALUE_W+1)/2{2'b10}});
      send_value({(VALUE_W+1)/2{2'b01}});

      // base 9: just below, at and above the base, just below and at its square
      write_base(4'd9);
      send_value(8);
      send_value(9);
      send_value(10);
      send_value(80);
      send_value(81);
      send_value(VALUE_MAX);

      // register values below range act as base 2
      write_base(4'd0);
      send_value(1);
      send_value(2);
      write_base(4'd1);
      send_value(5);

      // register values above range act as base 9
      write_base(4'd15);
      send_value(8);
      send_value(VALUE_MAX);
      write_base(4'd10);
      send_value(729);

      write_base(4'd5);
      send_value(4);
      send_value(124);
      send_value(125);

      // random phases, one base each
      for (int phase = 0; phase < 9; phase++) begin
         if (phase < 4) begin
            raw = phase_bases[phase];
         end else begin
            raw = rdc_pkg::RADIX_W'($urandom_range(0, 15));
         end
         write_base(raw);
         gaps_on = (phase % 3) != 1;
         repeat (30) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
                  v = VALUE_W'($urandom);
               end
               4, 5: begin
                  v = VALUE_W'($urandom_range(0, 3 * base_now));
               end
               6, 7: begin
                  // powers of the base and one below, where digit count steps
                  p = 1;
                  repeat ($urandom_range(1, VALUE_W)) begin
                     if (p * base_now <= longint'(VALUE_MAX)) p = p * base_now;
                  end
                  v = VALUE_W'(p - $urandom_range(0, 1));
               end
               default: begin
                  v = VALUE_W'($urandom) >> $urandom_range(1, VALUE_W - 1);
               end
            endcase
            send_value(v);
         end
      end

      // drain and give the verdict
      req_ch.valid <= 1'b0;
      while (digits_pending != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // watchdog
   initial begin
      #8000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire
